FILE: design/u8d_pkg.sv
// Shared types and constants for the strict UTF-8 decoder.
// No dependencies; every other design file depends on this package.
package u8d_pkg;

	localparam int unsigned CP_W      = 21;
	localparam int unsigned REP_W     = 3;	// replacement count, 0..4
	localparam int unsigned JOB_DEPTH = 4;
	localparam int unsigned JOB_AW    = $clog2(JOB_DEPTH);
	localparam int unsigned JOB_CW    = $clog2(JOB_DEPTH + 1);

	localparam logic [CP_W-1:0] REPL_CP     = 21'h00FFFD;
	localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
	localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
	localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;

	// Continuations expected by an open sequence
	localparam logic [1:0] SEQ_NONE = 2'd0;
	localparam logic [1:0] SEQ_TWO  = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR = 2'd3;

	// One queued job: n_rep replacement results, then optionally one code point
	typedef struct packed {
		logic [REP_W-1:0] n_rep;
		logic             has_cp;
		logic [CP_W-1:0]  cp;
	} job_t;

endpackage

FILE: design/u8d_if.sv
// Handshake channels of the strict UTF-8 decoder: byte in, code point out.
// Depends on u8d_pkg for the code point width.
interface u8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface u8d_cp_if;
	logic                     valid;
	logic                     ready;
	logic [u8d_pkg::CP_W-1:0] code_point;
	logic                     replaced;
	logic                     last_of_run;

	modport source (output valid, output code_point, output replaced,
		output last_of_run, input ready);
	modport sink (input valid, input code_point, input replaced,
		input last_of_run, output ready);
endinterface

FILE: design/u8d_front.sv
// Front end: takes bytes, tracks the open sequence, builds result jobs.
// Depends on u8d_pkg and u8d_byte_if.
module u8d_front (
	input  logic            clk,
	input  logic            arst_n,
	u8d_byte_if.sink        text_in,
	input  logic            queue_full,
	output logic            push,
	output u8d_pkg::job_t   job
);
	import u8d_pkg::*;

	logic [1:0]      seq_q, seq_n;
	logic [1:0]      cs_q, cs_n;
	logic [CP_W-1:0] acc_q, acc_n;
	logic [7:0]      b;
	logic            accept, is_cont, fresh, ok;
	logic [CP_W-1:0] shifted;
	logic [1:0]      cs_inc;

	assign b       = text_in.text_byte;
	assign accept  = text_in.valid && text_in.ready;
	assign is_cont = (b[7:6] == 2'b10);
	assign shifted = {acc_q[CP_W-7:0], b[5:0]};
	assign cs_inc  = cs_q + 2'd1;

	// range checks on a completed sequence
	always_comb begin
		ok = 1'b1;
		if (seq_q == SEQ_TWO && shifted < MIN_2BYTE) ok = 1'b0;
		if (seq_q == SEQ_THREE && shifted < MIN_3BYTE) ok = 1'b0;
		if (seq_q == SEQ_FOUR && shifted < MIN_4BYTE) ok = 1'b0;
		if (shifted >= SURR_LO && shifted <= SURR_HI) ok = 1'b0;
		if (shifted > CP_MAX) ok = 1'b0;
	end

	always_comb begin
		seq_n      = seq_q;
		cs_n       = cs_q;
		acc_n      = acc_q;
		fresh      = 1'b1;
		job.n_rep  = '0;
		job.has_cp = 1'b0;
		job.cp     = shifted;
		if (seq_q != SEQ_NONE) begin
			if (is_cont) begin
				fresh = 1'b0;
				acc_n = shifted;
				cs_n  = cs_inc;
				if (cs_inc == seq_q) begin
					if (ok) begin
						job.has_cp = 1'b1;
					end else begin
						job.n_rep = {1'b0, seq_q} + 3'd1;
					end
					seq_n = SEQ_NONE;
					cs_n  = '0;
					acc_n = '0;
				end
			end else begin
				// interrupted: lead plus each held continuation
				job.n_rep = {1'b0, cs_q} + 3'd1;
				seq_n = SEQ_NONE;
				cs_n  = '0;
				acc_n = '0;
			end
		end
		if (fresh && b != 8'h00) begin
			if (b[7] == 1'b0) begin
				job.has_cp = 1'b1;
				job.cp     = {13'd0, b};
			end else if (b[7:5] == 3'b110) begin
				seq_n = SEQ_TWO;
				cs_n  = '0;
				acc_n = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				seq_n = SEQ_THREE;
				cs_n  = '0;
				acc_n = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				seq_n = SEQ_FOUR;
				cs_n  = '0;
				acc_n = {18'd0, b[2:0]};
			end else begin
				// stray continuation or invalid lead
				job.n_rep = job.n_rep + 3'd1;
			end
		end
	end

	assign text_in.ready = !queue_full;
	assign push = accept && (job.n_rep != '0 || job.has_cp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_NONE;
			cs_q  <= '0;
			acc_q <= '0;
		end else if (accept) begin
			seq_q <= seq_n;
			cs_q  <= cs_n;
			acc_q <= acc_n;
		end
	end

endmodule

FILE: design/u8d_fifo.sv
// Job queue between the front end and the result emitter.
// Depends on u8d_pkg (job_t, JOB_DEPTH).
module u8d_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u8d_pkg::job_t   push_job,
	input  logic            pop,
	output u8d_pkg::job_t   head_job,
	output logic            not_empty,
	output logic            full
);
	import u8d_pkg::*;

	job_t              mem_q [JOB_DEPTH];
	logic [JOB_AW-1:0] wr_q, rd_q;
	logic [JOB_CW-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == JOB_CW'(JOB_DEPTH));
	assign head_job  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + JOB_AW'(1);
			if (pop) rd_q <= rd_q + JOB_AW'(1);
			if (push && !pop) begin
				cnt_q <= cnt_q + JOB_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - JOB_CW'(1);
			end
		end
	end

endmodule

FILE: design/u8d_back.sv
// Back end: expands one job into its result transactions, one per cycle while the output is ready.
// Depends on u8d_pkg and u8d_cp_if.
module u8d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  u8d_pkg::job_t   head_job,
	input  logic            not_empty,
	output logic            pop,
	u8d_cp_if.source        cp_out
);
	import u8d_pkg::*;

	logic             busy_q;
	logic [REP_W-1:0] rep_q;
	logic             has_cp_q;
	logic [CP_W-1:0]  cp_q;
	logic             rep_now, last, fire;

	assign rep_now = (rep_q != '0);
	assign last    = rep_now ? (rep_q == REP_W'(1) && !has_cp_q) : 1'b1;
	assign fire    = cp_out.valid && cp_out.ready;
	assign pop     = not_empty && (!busy_q || (fire && last));

	assign cp_out.valid       = busy_q;
	assign cp_out.code_point  = rep_now ? REPL_CP : cp_q;
	assign cp_out.replaced    = rep_now;
	assign cp_out.last_of_run = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rep_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			rep_q  <= head_job.n_rep;
		end else if (fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				rep_q <= rep_q - REP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			has_cp_q <= head_job.has_cp;
			cp_q     <= head_job.cp;
		end
	end

endmodule

FILE: design/strict_utf8_decoder_top.sv
// Strict UTF-8 decoder, top level: front end, job queue, result emitter.
// The first result of a byte is registered in the job queue, then in the emitter,
//   which then raises valid; a busy emitter can delay it further.
// Throughput: one byte per cycle; a byte makes 0 to 4 results, the emitter
//   sends one per cycle while the output is ready, the 4-entry job queue absorbs the bursts, and input
//   stalls only while that queue is full.
// Reset (arst_n low, asynchronous): no sequence open, queue and emitter empty.
// Depends on u8d_pkg, u8d_if, u8d_front, u8d_fifo, u8d_back.
module strict_utf8_decoder_top (
	input  logic     clk,
	input  logic     arst_n,
	u8d_byte_if.sink text_in,
	u8d_cp_if.source cp_out
);
	import u8d_pkg::*;

	// front -> queue
	logic push;
	job_t push_job;
	logic full;

	// queue -> back
	job_t head_job;
	logic not_empty;
	logic pop;

	// Front end: sequence state updates at every byte transaction; each
	// byte that causes results pushes one job (replacement count plus an
	// optional code point). Ready drops only when the queue is full, so it
	// never waits on the output side directly.
	u8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.queue_full (full),
		.push       (push),
		.job        (push_job)
	);

	// Short queue decouples the two sides.
	u8d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.head_job  (head_job),
		.not_empty (not_empty),
		.full      (full)
	);

	// Emitter: replacements first, then the code point; last_of_run marks
	// the final transaction of each job. Loads the next job in the same
	// cycle the last one leaves, so results stream without gaps while jobs are queued.
	u8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.not_empty (not_empty),
		.pop       (pop),
		.cp_out    (cp_out)
	);

endmodule
